>>> design/rpbc_pkg.sv
// Shared types and constants for the rotated projection bin counter.
// No dependencies; imported by rpbc_proj, rpbc_div and the core.
`default_nettype none

package rpbc_pkg;

    localparam int IMG_DIM  = 4096;
    localparam int MAX_BINS = 8192;

    // Field widths fixed by the request, result and configuration formats
    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int TRIG_W  = 18;
    localparam int AMIN_W  = 30;
    localparam int BW_W    = 29;
    localparam int NBIN_W  = 14;
    localparam int CNT_W   = 25;
    localparam int SEL_W   = 13;
    localparam int CFG_W   = 30;
    localparam int CFGI_W  = 3;

    // Store geometry
    localparam int BIN_W   = $clog2(MAX_BINS);
    localparam int LIMIT_W = $clog2(MAX_BINS) + 1;

    // Projection and divider datapath
    localparam int PROJ_W  = 32;
    localparam int DIVD_W  = PROJ_W - 1;
    localparam int DEN_W   = BW_W + BIN_W - 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] FUNC_BIN   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFGI_W-1:0] CFG_COS   = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_SIN   = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_AMIN  = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_BW    = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_NBINS = 3'd4;

    typedef struct packed {
        logic [1:0]       func;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             pixel_valid;
        logic [SEL_W-1:0] bin_select;
    } t_in_req;

    typedef struct packed {
        logic [SEL_W-1:0] bin_index;
        logic             binned;
        logic             out_of_range;
        logic [CNT_W-1:0] bin_count;
    } t_out_res;

endpackage

`default_nettype wire

>>> design/rpbc_ram.sv
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rpbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/rpbc_proj.sv
// Bit-serial projection: column*cos + row*sin, one column and row bit a cycle.
// Depends on rpbc_pkg.
`default_nettype none

module rpbc_proj (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [rpbc_pkg::COL_W-1:0]        i_column,
    input  wire logic [rpbc_pkg::ROW_W-1:0]        i_row,
    input  wire logic signed [rpbc_pkg::TRIG_W-1:0] i_cos,
    input  wire logic signed [rpbc_pkg::TRIG_W-1:0] i_sin,
    output logic                                   o_done,
    output logic [rpbc_pkg::PROJ_W-1:0]            o_proj
);
    import rpbc_pkg::*;

    localparam int STEP_W = $clog2(COL_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PROJ_W-1:0] r_cos_sh;
    logic [PROJ_W-1:0] r_sin_sh;
    logic [PROJ_W-1:0] r_acc;
    logic [PROJ_W-1:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (r_col[0]) n_acc = n_acc + r_cos_sh;
        if (r_row[0]) n_acc = n_acc + r_sin_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_step   <= '0;
                r_col    <= i_column;
                r_row    <= i_row;
                r_cos_sh <= {{(PROJ_W-TRIG_W){i_cos[TRIG_W-1]}}, i_cos};
                r_sin_sh <= {{(PROJ_W-TRIG_W){i_sin[TRIG_W-1]}}, i_sin};
                r_acc    <= '0;
            end else if (r_busy) begin
                r_acc    <= n_acc;
                r_col    <= r_col >> 1;
                r_row    <= r_row >> 1;
                r_cos_sh <= r_cos_sh << 1;
                r_sin_sh <= r_sin_sh << 1;
                r_step   <= r_step + 1'b1;
                if (r_step == STEP_W'(COL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_proj = r_acc;

endmodule

`default_nettype wire

>>> design/rpbc_div.sv
// Restoring divider, one quotient bit a cycle, quotient limited to the bin width.
// Depends on rpbc_pkg.
`default_nettype none

module rpbc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rpbc_pkg::DIVD_W-1:0] i_dividend,
    input  wire logic [rpbc_pkg::BW_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic                             o_ovf,
    output logic [rpbc_pkg::BIN_W-1:0]       o_quot
);
    import rpbc_pkg::*;

    localparam int STEP_W = $clog2(BIN_W);

    logic              r_busy;
    logic              r_done;
    logic              r_ovf;
    logic [STEP_W-1:0] r_step;
    logic [DIVD_W-1:0] r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [BIN_W-1:0]  r_quot;
    logic              w_ovf;
    logic              w_ge;

    // Quotient would need more than BIN_W bits: dividend >= divisor * 2^BIN_W
    assign w_ovf = {{(DEN_W+1-DIVD_W){1'b0}}, i_dividend} >= {i_divisor, {BIN_W{1'b0}}};
    assign w_ge  = {{(DEN_W-DIVD_W){1'b0}}, r_rem} >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ovf  <= w_ovf;
                r_rem  <= i_dividend;
                r_den  <= {i_divisor, {(BIN_W-1){1'b0}}};
                r_quot <= '0;
                r_step <= '0;
                r_busy <= !w_ovf;
                r_done <= w_ovf;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_den[DIVD_W-1:0];
                end
                r_quot <= {r_quot[BIN_W-2:0], w_ge};
                r_den  <= r_den >> 1;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(BIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> design/rotated_projection_bin_counter_core.sv
// Rotated projection bin counter: projects a pixel onto a rotated axis, bins it,
// and keeps per-bin counts in a RAM. Uses rpbc_pkg, rpbc_proj, rpbc_div, rpbc_ram.
// Pixel request: from accept to result valid it runs 12 serial projection
// steps, the offset, 13 divider steps and a RAM read-modify-write.
// Read or clear skip the projection and divider. Rejected pixels finish early.
// One request in flight; the next is taken while a result waits in the output.
// Reset: synchronous active low; then the whole count RAM is cleared,
// one entry a cycle, with the request channel stalled.
`default_nettype none

module rotated_projection_bin_counter_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire rpbc_pkg::t_in_req           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output rpbc_pkg::t_out_res               o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [rpbc_pkg::CFGI_W-1:0] i_cfg_index,
    input  wire logic [rpbc_pkg::CFG_W-1:0]  i_cfg_data
);
    import rpbc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MUL, S_SUB, S_DIV, S_RD, S_RDW, S_FIN
    } t_state;

    t_state r_state;

    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic [AMIN_W-1:0]        r_amin;
    logic [BW_W-1:0]          r_bw;
    logic [NBIN_W-1:0]        r_nbins;

    logic [BIN_W-1:0]  r_clr;
    logic [BIN_W-1:0]  r_addr;
    logic [1:0]        r_func;
    logic [PROJ_W-1:0] r_diff;
    t_out_res          r_res;
    t_out_res          r_out;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_out_free;
    logic [LIMIT_W-1:0] w_limit;
    logic [BW_W-1:0]   w_bw;
    logic              w_in_image;
    t_out_res          w_init_res;
    logic              w_proj_start;
    logic              w_proj_done;
    logic [PROJ_W-1:0] w_proj;
    logic              w_div_start;
    logic              w_div_done;
    logic              w_div_ovf;
    logic [BIN_W-1:0]  w_quot;
    logic              w_ram_we;
    logic [BIN_W-1:0]  w_ram_waddr;
    logic [CNT_W-1:0]  w_ram_wdata;
    logic              w_ram_re;
    logic [CNT_W-1:0]  w_ram_rdata;
    logic [CNT_W-1:0]  w_new_count;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_limit = ({{(32-NBIN_W){1'b0}}, r_nbins} > 32'(MAX_BINS))
                   ? LIMIT_W'(MAX_BINS) : LIMIT_W'(r_nbins);
    assign w_bw    = (r_bw == '0) ? BW_W'(1) : r_bw;

    assign w_in_image = ({{(32-COL_W){1'b0}}, i_in_data.column} < 32'(IMG_DIM))
                     && ({{(32-ROW_W){1'b0}}, i_in_data.row} < 32'(IMG_DIM));

    // Result fields known at accept time
    always_comb begin
        w_init_res = '0;
        case (i_in_data.func)
            FUNC_BIN: begin
                w_init_res.out_of_range = i_in_data.pixel_valid && !w_in_image;
            end
            FUNC_READ, FUNC_CLEAR: begin
                w_init_res.bin_index    = i_in_data.bin_select;
                w_init_res.out_of_range = ({1'b0, i_in_data.bin_select} >= w_limit);
            end
            default: ;
        endcase
    end

    assign w_proj_start = w_accept && (i_in_data.func == FUNC_BIN)
                       && i_in_data.pixel_valid && w_in_image;
    // Negative offset means a bin below zero, so only a non-negative offset is divided
    assign w_div_start  = (r_state == S_SUB) && !r_diff[PROJ_W-1];

    rpbc_proj u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_proj_start),
        .i_column (i_in_data.column),
        .i_row    (i_in_data.row),
        .i_cos    (r_cos),
        .i_sin    (r_sin),
        .o_done   (w_proj_done),
        .o_proj   (w_proj)
    );

    rpbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_diff[DIVD_W-1:0]),
        .i_divisor  (w_bw),
        .o_done     (w_div_done),
        .o_ovf      (w_div_ovf),
        .o_quot     (w_quot)
    );

    always_comb begin
        case (r_func)
            FUNC_BIN:   w_new_count = (w_ram_rdata == COUNT_MAX)
                                    ? w_ram_rdata : w_ram_rdata + 1'b1;
            FUNC_CLEAR: w_new_count = '0;
            default:    w_new_count = w_ram_rdata;
        endcase
    end

    assign w_ram_re    = (r_state == S_RD);
    assign w_ram_we    = (r_state == S_CLEAR)
                      || ((r_state == S_RDW) && (r_func != FUNC_READ));
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0 : w_new_count;

    rpbc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BINS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cos       <= TRIG_W'(65536);
            r_sin       <= '0;
            r_amin      <= '0;
            r_bw        <= BW_W'(65536);
            r_nbins     <= NBIN_W'(1);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COS:   r_cos   <= i_cfg_data[TRIG_W-1:0];
                    CFG_SIN:   r_sin   <= i_cfg_data[TRIG_W-1:0];
                    CFG_AMIN:  r_amin  <= i_cfg_data[AMIN_W-1:0];
                    CFG_BW:    r_bw    <= i_cfg_data[BW_W-1:0];
                    CFG_NBINS: r_nbins <= i_cfg_data[NBIN_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BIN_W'(MAX_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_func <= i_in_data.func;
                        r_res  <= w_init_res;
                        r_addr <= i_in_data.bin_select;
                        case (i_in_data.func)
                            FUNC_BIN: begin
                                if (!i_in_data.pixel_valid || !w_in_image) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            FUNC_READ, FUNC_CLEAR: begin
                                if (w_init_res.out_of_range) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_MUL: begin
                    if (w_proj_done) begin
                        r_diff  <= w_proj - {{(PROJ_W-AMIN_W){r_amin[AMIN_W-1]}}, r_amin};
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (r_diff[PROJ_W-1]) begin
                        r_res.out_of_range <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (w_div_ovf || ({1'b0, w_quot} >= w_limit)) begin
                            r_res.out_of_range <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_addr  <= w_quot;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_res.bin_count <= w_new_count;
                    if (r_func == FUNC_BIN) begin
                        r_res.bin_index <= r_addr;
                        r_res.binned    <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted request keeps the channel stalled until its result is formed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("request channel open right after accept");

    // A counted pixel is never flagged and always carries a nonzero count
    a_binned_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.binned)
        |-> (!o_out_data.out_of_range && (o_out_data.bin_count != '0)))
        else $error("binned result flagged or with zero count");

    // Out of range results report no count and no counting
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_of_range)
        |-> (!o_out_data.binned && (o_out_data.bin_count == '0)))
        else $error("out of range result with count");

    // The count store is only written while clearing or finishing a request
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_ram_we)
        else $error("count RAM written while idle");

endmodule

`default_nettype wire
